// ----- hw/rtl/lgrs_pkg.sv -----
// Package with shared constants, types and the column mask function for the Life row stream unit.
package lgrs_pkg;

    localparam int MAX_COLS   = 64;
    localparam int COL_W      = $clog2(MAX_COLS + 1);
    localparam int NUM_LANES  = 4;
    localparam int LANE_W     = MAX_COLS / NUM_LANES;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_LW    = $clog2(FIFO_DEPTH + 1);

    typedef logic [MAX_COLS-1:0] row_t;

    // Number of rows currently held for the neighbor window.
    typedef enum logic [1:0] {
        HELD_NONE = 2'd0,
        HELD_ONE  = 2'd1,
        HELD_TWO  = 2'd2
    } held_t;

    typedef struct packed {
        logic final_row;
        row_t next_row;
    } result_t;

    typedef struct packed {
        logic push_a;
        logic push_b;
    } push_t;

    typedef struct packed {
        logic               room_for_two;
        logic [FIFO_LW-1:0] level;
    } fifo_status_t;

    // Mask of the columns in use; zero acts as one column, large values as all columns.
    function automatic row_t width_mask(input logic [COL_W-1:0] cols);
        logic [COL_W-1:0] eff;
        row_t             mask;
        eff = cols;
        if (eff == '0) begin
            eff = COL_W'(1);
        end
        if (eff > COL_W'(MAX_COLS)) begin
            eff = COL_W'(MAX_COLS);
        end
        for (int i = 0; i < MAX_COLS; i++) begin
            mask[i] = (COL_W'(i) < eff);
        end
        return mask;
    endfunction

endpackage

// ----- hw/rtl/lgrs_lane.sv -----
// One lane of Life cells: neighbor counts and the B3/S23 rule over a slice of columns.
module lgrs_lane (
    input  logic [lgrs_pkg::LANE_W+1:0] above_i,
    input  logic [lgrs_pkg::LANE_W+1:0] here_i,
    input  logic [lgrs_pkg::LANE_W+1:0] below_i,
    output logic [lgrs_pkg::LANE_W-1:0] next_o
);

    // Bit 0 and the top bit of each input are the neighbor columns outside this slice.
    logic [3:0] nbr_count [lgrs_pkg::LANE_W];

    always_comb begin
        for (int j = 0; j < lgrs_pkg::LANE_W; j++) begin
            nbr_count[j] = 4'(above_i[j]) + 4'(above_i[j+1]) + 4'(above_i[j+2])
                         + 4'(here_i[j]) + 4'(here_i[j+2])
                         + 4'(below_i[j]) + 4'(below_i[j+1]) + 4'(below_i[j+2]);
            next_o[j] = (nbr_count[j] == 4'd3) || ((nbr_count[j] == 4'd2) && here_i[j+1]);
        end
    end

endmodule

// ----- hw/rtl/lgrs_result_fifo.sv -----
// Small result queue that takes up to two results a cycle and drives the output stream.
module lgrs_result_fifo (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lgrs_pkg::push_t        push_i,
    input  lgrs_pkg::result_t      res_a_i,
    input  lgrs_pkg::result_t      res_b_i,
    output lgrs_pkg::fifo_status_t status_o,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output lgrs_pkg::result_t      m_res_o
);

    lgrs_pkg::result_t                 mem_reg [lgrs_pkg::FIFO_DEPTH];
    logic [lgrs_pkg::FIFO_AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [lgrs_pkg::FIFO_AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [lgrs_pkg::FIFO_LW-1:0]      level_reg, level_next;
    logic [lgrs_pkg::FIFO_AW-1:0]      wr_ptr_plus1;
    logic                              pop;

    assign pop          = m_tvalid && m_tready;
    assign wr_ptr_plus1 = wr_ptr_reg + lgrs_pkg::FIFO_AW'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + lgrs_pkg::FIFO_AW'(push_i.push_a)
                    + lgrs_pkg::FIFO_AW'(push_i.push_b);
        rd_ptr_next = rd_ptr_reg + lgrs_pkg::FIFO_AW'(pop);
        level_next  = level_reg + lgrs_pkg::FIFO_LW'(push_i.push_a)
                    + lgrs_pkg::FIFO_LW'(push_i.push_b) - lgrs_pkg::FIFO_LW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // The second result of a cycle always follows the first one.
    always_ff @(posedge aclk) begin
        if (push_i.push_a) begin
            mem_reg[wr_ptr_reg] <= res_a_i;
        end
        if (push_i.push_b) begin
            mem_reg[wr_ptr_plus1] <= res_b_i;
        end
    end

    assign m_tvalid              = (level_reg != '0);
    assign m_res_o               = mem_reg[rd_ptr_reg];
    assign status_o.level        = level_reg;
    assign status_o.room_for_two =
        (level_reg <= lgrs_pkg::FIFO_LW'(lgrs_pkg::FIFO_DEPTH - 2));

endmodule

// ----- hw/rtl/life_generation_row_stream_unit.sv -----
// Top level of the streaming Life (B3/S23) generation unit, one grid row per transaction.
//
// The unit computes one generation of Conway's Life on a grid with dead borders. Rows of the
// current generation arrive top to bottom, one per input transaction, as a 64-bit mask in
// s_tdata (bit i is column i); s_tlast marks the bottom row. Every row after the first yields
// the next generation of the row above it, and the bottom row also yields its own next row with
// m_tlast set, after which the unit starts a new grid. A one-row grid yields one result with
// m_tlast set. Columns at or above cols_in_use (written through cfg_wr_en/cfg_wr_data, reset
// 64, zero acting as one) are dead on input and zero on output; write it only while the unit
// is idle. For each transaction the new row, the two held rows and four parallel 16-column
// lanes per result form the whole neighbor count, so s_tready stays high and one row is
// accepted every clock while results are taken. Each result is registered in the result
// queue before it reaches the output, in order. Results pass through a four-entry queue; the
// bottom row puts two results into it while the top row puts none, so a grid of R rows
// yields R results, and both sides keep pace when they run continuously. s_tready is low
// only while that queue lacks room for two results.
module life_generation_row_stream_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration: cols_in_use.
    input  logic                          cfg_wr_en,
    input  logic [lgrs_pkg::COL_W-1:0]    cfg_wr_data,
    // Input rows.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lgrs_pkg::MAX_COLS-1:0] s_tdata,   // [63:0] row_cells
    input  logic                          s_tlast,   // end_of_grid
    // Next-generation rows.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lgrs_pkg::MAX_COLS-1:0] m_tdata,   // [63:0] next_row
    output logic                          m_tlast    // final_row
);

    localparam int PAD_W = lgrs_pkg::MAX_COLS + 2;

    logic [lgrs_pkg::COL_W-1:0] cols_reg;
    lgrs_pkg::held_t            held_reg, held_next;
    lgrs_pkg::row_t             older_reg, older_next;
    lgrs_pkg::row_t             middle_reg, middle_next;

    lgrs_pkg::row_t             mask;
    lgrs_pkg::row_t             cur_row;
    logic                       s_fire;

    lgrs_pkg::row_t             a_above, a_here, a_below;
    logic [PAD_W-1:0]           a_above_pad, a_here_pad, a_below_pad;
    logic [PAD_W-1:0]           b_above_pad, b_here_pad, b_below_pad;
    lgrs_pkg::row_t             a_lanes, b_lanes;

    lgrs_pkg::push_t            push;
    lgrs_pkg::result_t          res_a, res_b, m_res;
    lgrs_pkg::fifo_status_t     fifo_status;

    // The column count is a plain register written whenever the enable is high.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= lgrs_pkg::COL_W'(lgrs_pkg::MAX_COLS);
        end else if (cfg_wr_en) begin
            cols_reg <= cfg_wr_data;
        end
    end

    assign mask     = lgrs_pkg::width_mask(cols_reg);
    assign cur_row  = s_tdata & mask;
    assign s_tready = fifo_status.room_for_two;
    assign s_fire   = s_tvalid && s_tready;

    // The first result uses the held window; with no rows held it is the lone bottom row.
    always_comb begin
        if (held_reg == lgrs_pkg::HELD_NONE) begin
            a_above = '0;
            a_here  = cur_row;
            a_below = '0;
        end else begin
            a_above = older_reg & mask;
            a_here  = middle_reg & mask;
            a_below = cur_row;
        end
    end

    // Zero columns on each side give the dead border to the outer lanes.
    assign a_above_pad = {1'b0, a_above, 1'b0};
    assign a_here_pad  = {1'b0, a_here, 1'b0};
    assign a_below_pad = {1'b0, a_below, 1'b0};
    assign b_above_pad = {1'b0, middle_reg & mask, 1'b0};
    assign b_here_pad  = {1'b0, cur_row, 1'b0};
    assign b_below_pad = '0;

    // Each lane sees its own columns plus one neighbor column on either side.
    for (genvar k = 0; k < lgrs_pkg::NUM_LANES; k++) begin : g_lane
        lgrs_lane u_lane_a (
            .above_i (a_above_pad[k*lgrs_pkg::LANE_W +: lgrs_pkg::LANE_W+2]),
            .here_i  (a_here_pad[k*lgrs_pkg::LANE_W +: lgrs_pkg::LANE_W+2]),
            .below_i (a_below_pad[k*lgrs_pkg::LANE_W +: lgrs_pkg::LANE_W+2]),
            .next_o  (a_lanes[k*lgrs_pkg::LANE_W +: lgrs_pkg::LANE_W])
        );
        lgrs_lane u_lane_b (
            .above_i (b_above_pad[k*lgrs_pkg::LANE_W +: lgrs_pkg::LANE_W+2]),
            .here_i  (b_here_pad[k*lgrs_pkg::LANE_W +: lgrs_pkg::LANE_W+2]),
            .below_i (b_below_pad[k*lgrs_pkg::LANE_W +: lgrs_pkg::LANE_W+2]),
            .next_o  (b_lanes[k*lgrs_pkg::LANE_W +: lgrs_pkg::LANE_W])
        );
    end

    // Merge: the lane slices form the row, and a cell just past the last column may be born
    // from its neighbors, so the result is masked again.
    always_comb begin
        res_a.next_row  = a_lanes & mask;
        res_a.final_row = s_tlast && (held_reg == lgrs_pkg::HELD_NONE);
        res_b.next_row  = b_lanes & mask;
        res_b.final_row = 1'b1;
    end

    // Row window control: how many rows are held decides what one transaction produces.
    always_comb begin
        held_next   = held_reg;
        older_next  = older_reg;
        middle_next = middle_reg;
        push.push_a = 1'b0;
        push.push_b = 1'b0;
        if (s_fire) begin
            unique case (held_reg)
                lgrs_pkg::HELD_NONE: begin
                    if (s_tlast) begin
                        push.push_a = 1'b1;
                        older_next  = '0;
                        middle_next = '0;
                    end else begin
                        older_next  = '0;
                        middle_next = cur_row;
                        held_next   = lgrs_pkg::HELD_ONE;
                    end
                end
                default: begin
                    push.push_a = 1'b1;
                    if (s_tlast) begin
                        push.push_b = 1'b1;
                        older_next  = '0;
                        middle_next = '0;
                        held_next   = lgrs_pkg::HELD_NONE;
                    end else begin
                        older_next  = middle_reg;
                        middle_next = cur_row;
                        held_next   = lgrs_pkg::HELD_TWO;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg   <= lgrs_pkg::HELD_NONE;
            older_reg  <= '0;
            middle_reg <= '0;
        end else begin
            held_reg   <= held_next;
            older_reg  <= older_next;
            middle_reg <= middle_next;
        end
    end

    lgrs_result_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_i   (push),
        .res_a_i  (res_a),
        .res_b_i  (res_b),
        .status_o (fifo_status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res_o  (m_res)
    );

    assign m_tdata = m_res.next_row;
    assign m_tlast = m_res.final_row;

`ifndef NO_ASSERTIONS
    // The queue never holds more results than it has entries.
    a_fifo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_status.level <= lgrs_pkg::FIFO_LW'(lgrs_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    // A bottom row closes the grid.
    a_grid_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_tlast |=> held_reg == lgrs_pkg::HELD_NONE)
        else $error("grid not closed after bottom row");

    // Any other row leaves at least one row held.
    a_row_held: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && !s_tlast |=> held_reg != lgrs_pkg::HELD_NONE)
        else $error("row not held");

    // Columns beyond the configured width are never alive on the output.
    a_out_masked: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata & ~mask) == '0)
        else $error("live cell beyond configured width");
`endif

endmodule
